// ===== sv/upd_pkg.sv =====
// Shared constants and helper functions for the URL percent decoder.
// No dependencies; compile first.
package upd_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] PCT_CHAR   = 8'h25;
    localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    localparam int SAFE_N = 10;
    localparam logic [SAFE_N-1:0][BYTE_W-1:0] SAFE_LIST = {
        8'h7D, 8'h7B, 8'h5D, 8'h5B, 8'h3E, 8'h3C, 8'h3A, 8'h2F, 8'h22, 8'h20
    };

    // Hex digit decode result: ok is low for any non-hex character.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_val(input logic [BYTE_W-1:0] c);
        t_hex r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h61 + 8'd10);
        end
        return r;
    endfunction

    function automatic logic on_safe_list(input logic [BYTE_W-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < SAFE_N; k++) begin
            if (SAFE_LIST[k] == v) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== sv/upd_in_if.sv =====
// Input channel of the URL percent decoder: one encoded character per transaction.
// Depends on upd_pkg.
interface upd_in_if;
    logic                       valid;
    logic                       ready;
    logic [upd_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== sv/upd_out_if.sv =====
// Output channel of the URL percent decoder: one decoded character per transaction.
// Depends on upd_pkg.
interface upd_out_if;
    logic                       valid;
    logic                       ready;
    logic [upd_pkg::BYTE_W-1:0] out_byte;
    logic                       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== sv/url_percent_decoder.sv =====
// Path: an input transaction passes the input register, group register and output register
//   before its first result. A character that only advances an escape yields none.
// Throughput: one character per cycle while the output is ready and each character yields
//   at most one result; a group of two or three results holds the single output port.
// Reset: synchronous, active low; clears mode to full decoding, no escape pending, all empty.
// URL percent decoder top level. Depends on upd_pkg, upd_in_if, upd_out_if.
module url_percent_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    upd_in_if.sink       i_in_ch,
    upd_out_if.source    o_out_ch
);

    localparam int BW = upd_pkg::BYTE_W;

    // Escape tracker: idle, after '%', after '%' plus one held character.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HELD = 3'b100
    } t_phase;

    typedef logic [1:0] t_cnt;

    // Up to three results produced by one input character.
    typedef struct packed {
        t_cnt               cnt;
        logic               last;
        logic [2:0][BW-1:0] data;
    } t_grp;

    // Configuration
    logic          r_mode;      // 0 full decoding, 1 safe-list only

    // Input register
    logic          r_in_vld;
    logic [BW-1:0] r_in_byte;
    logic          r_in_last;

    // Escape state
    t_phase        r_phase, n_phase;
    logic [BW-1:0] r_held, n_held;

    // Group register (B) and output register (A)
    logic          r_b_vld;
    t_grp          r_b;
    logic          r_a_vld;
    t_grp          r_a;
    t_cnt          r_idx;

    // Decode signals
    t_grp          g;
    logic          safe;
    logic          p_hold;
    logic [BW-1:0] p_byte;
    upd_pkg::t_hex hc, hh;
    logic [BW-1:0] v;

    // Flow control
    logic          in_acc, out_acc;
    logic          a_done, a_free, b_move, b_free, fire;

    //------------------------------------------------------------------
    // Handshake and flow between stages
    //------------------------------------------------------------------
    assign out_acc = r_a_vld && o_out_ch.ready;
    assign a_done  = out_acc && (r_idx == r_a.cnt - t_cnt'(1));
    assign a_free  = !r_a_vld || a_done;
    assign b_move  = r_b_vld && a_free;
    assign b_free  = !r_b_vld || b_move;
    // Decode the held character once the group register can take its results.
    assign fire    = r_in_vld && b_free;

    assign i_in_ch.ready = !r_in_vld || fire;
    assign in_acc        = i_in_ch.valid && i_in_ch.ready;

    assign o_out_ch.valid    = r_a_vld;
    assign o_out_ch.out_byte = r_a.data[r_idx];
    assign o_out_ch.out_last = r_a.last && (r_idx == r_a.cnt - t_cnt'(1));

    //------------------------------------------------------------------
    // Character decode
    //------------------------------------------------------------------
    assign safe = r_mode;

    // Plain handling of the current character: a '%' opens an escape unless it
    // ends the string; in full mode '+' turns into a space.
    assign p_hold = (r_in_byte == upd_pkg::PCT_CHAR) && !r_in_last;
    assign p_byte = (!safe && r_in_byte == upd_pkg::PLUS_CHAR) ? upd_pkg::SPACE_CHAR
                                                                : r_in_byte;

    assign hc = upd_pkg::hex_val(r_in_byte);
    assign hh = upd_pkg::hex_val(r_held);
    assign v  = {hh.val, hc.val};

    always_comb begin
        g       = '0;
        n_phase = PH_IDLE;
        n_held  = r_held;
        unique case (r_phase)
            PH_PCT: begin
                if (!safe && !hc.ok) begin
                    // Full mode, not hex: release the '%' and treat the character as plain.
                    g.data[0] = upd_pkg::PCT_CHAR;
                    if (p_hold) begin
                        g.cnt   = t_cnt'(1);
                        n_phase = PH_PCT;
                        n_held  = '0;
                    end else begin
                        g.data[1] = p_byte;
                        g.cnt     = t_cnt'(2);
                    end
                end else if (r_in_last) begin
                    // String ends after one character of the escape: flush as is.
                    g.data[0] = upd_pkg::PCT_CHAR;
                    g.data[1] = r_in_byte;
                    g.cnt     = t_cnt'(2);
                end else begin
                    n_held  = r_in_byte;
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                if (hh.ok && hc.ok && (!safe || upd_pkg::on_safe_list(v))) begin
                    g.data[0] = v;
                    g.cnt     = t_cnt'(1);
                end else if (safe) begin
                    // Triple not on the safe list: pass all three through.
                    g.data[0] = upd_pkg::PCT_CHAR;
                    g.data[1] = r_held;
                    g.data[2] = r_in_byte;
                    g.cnt     = t_cnt'(3);
                end else begin
                    // Full mode, bad second digit: release '%' and held digit.
                    g.data[0] = upd_pkg::PCT_CHAR;
                    g.data[1] = r_held;
                    if (p_hold) begin
                        g.cnt   = t_cnt'(2);
                        n_phase = PH_PCT;
                        n_held  = '0;
                    end else begin
                        g.data[2] = p_byte;
                        g.cnt     = t_cnt'(3);
                    end
                end
            end
            default: begin
                if (p_hold) begin
                    n_phase = PH_PCT;
                    n_held  = '0;
                end else begin
                    g.data[0] = p_byte;
                    g.cnt     = t_cnt'(1);
                end
            end
        endcase
        g.last = r_in_last;
        // End of string always leaves no escape pending.
        if (r_in_last) begin
            n_phase = PH_IDLE;
            n_held  = '0;
        end
    end

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_in_vld <= 1'b0;
            r_phase  <= PH_IDLE;
            r_held   <= '0;
            r_b_vld  <= 1'b0;
            r_a_vld  <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end

            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end

            if (fire) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end

            // Drop empty groups; they carry no result.
            if (fire && g.cnt != '0) begin
                r_b_vld <= 1'b1;
            end else if (b_move) begin
                r_b_vld <= 1'b0;
            end

            if (b_move) begin
                r_a_vld <= 1'b1;
                r_idx   <= '0;
            end else if (a_done) begin
                r_a_vld <= 1'b0;
            end else if (out_acc) begin
                r_idx <= r_idx + t_cnt'(1);
            end
        end
    end

    //------------------------------------------------------------------
    // Payload registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in_ch.in_byte;
            r_in_last <= i_in_ch.in_last;
        end
        if (fire && g.cnt != '0) begin
            r_b <= g;
        end
        if (b_move) begin
            r_a <= r_b;
        end
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_out_grp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> (r_a.cnt != '0 && r_idx < r_a.cnt))
        else $error("output group empty or index past its count");

    a_grp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> r_b.cnt != '0)
        else $error("queued group has no results");

    a_last_clears_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_phase == PH_IDLE && r_held == '0))
        else $error("escape still pending after end of string");

    a_grp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !b_move) |=> (r_b_vld && $stable(r_b)))
        else $error("queued group changed while waiting");

    a_no_fire_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> (!r_b_vld || a_free))
        else $error("decode fired with no room for its results");

endmodule

// ===== test/upd_decode_check.sv =====
`timescale 1ns / 1ps
// Checker for the URL percent decoder: watches both channels and the mode write port,
// predicts the decoded characters and compares them. Depends on upd_pkg and the channel
// interfaces.
module upd_decode_check (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    upd_in_if    i_in_mon,
    upd_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HELD = 3'b100
    } t_esc_phase;

    typedef struct packed {
        logic [upd_pkg::BYTE_W-1:0] ch;
        logic                       last;
    } t_dec_char;

    logic                       safe_mode;
    t_esc_phase                 phase;
    logic [upd_pkg::BYTE_W-1:0] held;
    t_dec_char                  step_buf [3];
    int                         step_n;
    t_dec_char                  decoded_q [$];
    int                         fails;
    int                         checked;

    function automatic logic is_hex(input logic [upd_pkg::BYTE_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // Valid only for hex characters; folds lower and upper case together.
    function automatic logic [3:0] hex_of(input logic [upd_pkg::BYTE_W-1:0] c);
        if (c <= "9") begin
            return 4'(c - "0");
        end
        return 4'((c | 8'h20) - "a" + 10);
    endfunction

    function automatic logic safe_code(input logic [upd_pkg::BYTE_W-1:0] v);
        case (v)
            8'h20, 8'h22, 8'h2F, 8'h3A, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic emit(input logic [upd_pkg::BYTE_W-1:0] b);
        step_buf[step_n] = '{ch: b, last: 1'b0};
        step_n++;
    endtask

    // Character seen with no escape open.
    task automatic take_plain(input logic [upd_pkg::BYTE_W-1:0] c, input logic last);
        phase = ESC_NONE;
        if (c == upd_pkg::PCT_CHAR && !last) begin
            phase = ESC_PCT;
            held  = '0;
        end else if (!safe_mode && c == upd_pkg::PLUS_CHAR) begin
            emit(upd_pkg::SPACE_CHAR);
        end else begin
            emit(c);
        end
    endtask

    task automatic decode_char(input logic [upd_pkg::BYTE_W-1:0] c, input logic last);
        logic [upd_pkg::BYTE_W-1:0] code;
        logic                       both_hex;
        step_n   = 0;
        code     = {hex_of(held), hex_of(c)};
        both_hex = is_hex(held) && is_hex(c);
        unique case (phase)
            ESC_PCT: begin
                if (!safe_mode && !is_hex(c)) begin
                    emit(upd_pkg::PCT_CHAR);
                    take_plain(c, last);
                end else if (last) begin
                    emit(upd_pkg::PCT_CHAR);
                    emit(c);
                    phase = ESC_NONE;
                end else begin
                    held  = c;
                    phase = ESC_HELD;
                end
            end
            ESC_HELD: begin
                if (both_hex && (!safe_mode || safe_code(code))) begin
                    emit(code);
                    phase = ESC_NONE;
                end else if (safe_mode) begin
                    emit(upd_pkg::PCT_CHAR);
                    emit(held);
                    emit(c);
                    phase = ESC_NONE;
                end else begin
                    emit(upd_pkg::PCT_CHAR);
                    emit(held);
                    take_plain(c, last);
                end
            end
            default: take_plain(c, last);
        endcase
        if (last) begin
            phase = ESC_NONE;
            held  = '0;
            if (step_n > 0) begin
                step_buf[step_n-1].last = 1'b1;
            end
        end
        for (int k = 0; k < step_n; k++) begin
            decoded_q = {decoded_q, step_buf[k]};
        end
    endtask

    always @(posedge i_clk) begin
        t_dec_char want;
        if (!i_rst_n) begin
            safe_mode = 1'b0;
            phase     = ESC_NONE;
            held      = '0;
            decoded_q.delete();
            fails     = 0;
            checked   = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("out_byte: expected nothing, actual %h (out_last %b)",
                           i_out_mon.out_byte, i_out_mon.out_last);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    checked++;
                    if (i_out_mon.out_byte !== want.ch) begin
                        $error("out_byte: expected %h, actual %h", want.ch, i_out_mon.out_byte);
                        fails++;
                    end
                    if (i_out_mon.out_last !== want.last) begin
                        $error("out_last: expected %b, actual %b", want.last,
                               i_out_mon.out_last);
                        fails++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_char(i_in_mon.in_byte, i_in_mon.in_last);
            end
            if (i_cfg_we) begin
                safe_mode = i_cfg_wdata;
            end
        end
        o_fail_count <= fails;
        o_pending    <= decoded_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== test/tb_url_percent_decoder.sv =====
`timescale 1ns / 1ps
// Testbench top for the URL percent decoder: clock, reset, stimulus and verdict.
// Depends on upd_pkg, upd_in_if, upd_out_if, url_percent_decoder and upd_decode_check.
module tb_url_percent_decoder;

    // Cycles to let pass after the last result before a mode write or the verdict;
    // keep a margin on top of the block's own latency.
    localparam int DRAIN_CYCLES = 10;

    // The ten characters that safe mode decodes.
    localparam logic [upd_pkg::BYTE_W-1:0] SAFE_CODES [10] = '{
        8'h20, 8'h22, 8'h2F, 8'h3A, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D
    };

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_wdata;
    logic                       calm;        // high during the stretch with no idling
    int                         sent;        // accepted input transactions
    int                         mode_writes;
    int                         fails;
    int                         pending;
    int                         checked;
    logic [upd_pkg::BYTE_W-1:0] text_q [$];  // encoded string being sent

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    url_percent_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    upd_decode_check u_decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver side: drop ready in about 6 percent of cycles, never during the calm stretch.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // Send one character; hold valid until the transaction completes.
    // Insert random idle cycles first so that gaps land on every escape phase.
    task automatic send_char(input logic [upd_pkg::BYTE_W-1:0] b, input logic last);
        while (!calm && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        sent++;
    endtask

    // Send a whole string, marking its final character.
    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], k == s.len() - 1);
        end
    endtask

    // Wait until every expected character is out, let the pipeline settle
    // (an escape in flight yields nothing), then write the mode register.
    task automatic set_mode(input logic m);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_writes++;
    endtask

    function automatic logic [upd_pkg::BYTE_W-1:0] hex_char(input logic [3:0] n);
        if (n < 10) begin
            return 8'("0" + n);
        end
        return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
    endfunction

    // Build a string from random tokens: a mix of well-formed escapes with random
    // content, some broken or lone escapes, plus signs and arbitrary bytes.
    task automatic send_random_text();
        int                         tokens;
        int                         r;
        logic [upd_pkg::BYTE_W-1:0] code;
        tokens = $urandom_range(6, 1);
        text_q.delete();
        repeat (tokens) begin
            r = $urandom_range(99);
            if (r < 35) begin
                code = $urandom_range(1) ? SAFE_CODES[$urandom_range(9)]
                                         : 8'($urandom_range(255));
                text_q = {text_q, upd_pkg::PCT_CHAR};
                text_q = {text_q, hex_char(code[7:4])};
                text_q = {text_q, hex_char(code[3:0])};
            end else if (r < 50) begin
                // Broken escape: a hex digit or junk, then junk half of the time.
                text_q = {text_q, upd_pkg::PCT_CHAR};
                text_q = {text_q, $urandom_range(1) ? hex_char(4'($urandom_range(15)))
                                                    : 8'($urandom_range(255))};
                if ($urandom_range(1)) begin
                    text_q = {text_q, 8'($urandom_range(255))};
                end
            end else if (r < 60) begin
                text_q = {text_q, upd_pkg::PLUS_CHAR};
            end else if (r < 65) begin
                text_q = {text_q, upd_pkg::PCT_CHAR};
            end else begin
                text_q = {text_q, 8'($urandom_range(255))};
            end
        end
        foreach (text_q[k]) begin
            send_char(text_q[k], k == text_q.size() - 1);
        end
    endtask

    initial begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 1'b0;
        calm          <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.in_last <= 1'b0;
        sent        = 0;
        mode_writes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full mode after reset.
        send_str("%4a");           // lower-case hex escape
        send_str("%G+");           // bad first digit, then plus becomes space
        send_str("%4%41");         // bad second digit that opens a new escape
        send_str("%");             // lone percent at the end of the string
        send_str("%4");            // string ends with one digit held
        send_char(8'h00, 1'b1);    // field extremes
        send_char(8'hFF, 1'b1);

        // Open an escape in full mode, switch to safe mode, finish it there.
        send_char(upd_pkg::PCT_CHAR, 1'b0);
        set_mode(1'b1);
        send_str("2F");

        // Safe mode: plus kept, off-list triple passed through, percent as held char.
        send_str("+%41");
        send_str("%%+");

        // Random part: alternate modes, the third phase runs with no idling at all.
        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph[0]);
            calm <= (ph == 2);
            while (sent < 25 + (ph + 1) * 85) begin
                send_random_text();
            end
        end

        // Drain: release valid, wait for every expected character, then settle.
        in_ch.valid <= 1'b0;
        calm        <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d encoded characters over %0d mode writes in both modes,",
                 sent, mode_writes);
        $display("with %0d decoded characters compared.", checked);
        if (fails == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/upd_pkg.sv
sv/upd_in_if.sv
sv/upd_out_if.sv
sv/url_percent_decoder.sv
test/upd_decode_check.sv
test/tb_url_percent_decoder.sv
